@@ design/tmcw_pkg.sv @@
// Package for the text-mode console writer: screen geometry, byte codes,
// channel payload types and the command/status structs between controller and datapath.
// Depends on nothing; every other design file imports it.
`default_nettype none

package tmcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int MOVE_CELLS = COLUMNS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELLS);

  // Field widths of the channels.
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = 11;
  localparam int DATA_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;

  localparam int TAB_SPACES = 4;
  localparam int TAB_W      = $clog2(TAB_SPACES);

  localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0]  CHAR_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_RESET    = 8'd7;
  localparam logic [DATA_W-1:0]  CURSOR_MARK    = 16'hF000;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    CLS_PLAIN,
    CLS_NEWLINE,
    CLS_BACKSPACE,
    CLS_TAB,
    CLS_READ
  } item_class_t;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
  } result_t;

  typedef struct packed {
    logic accept;         // latch the offered word
    logic sweep_clr;      // sweep address back to zero
    logic sweep_inc;      // sweep address plus one
    logic rd_item;        // read the cell at the latched index
    logic rd_sweep;       // read the cell one row below the sweep address
    logic rd_cursor;      // read the cursor cell
    logic wr_sweep_copy;  // write the read data at the sweep address
    logic wr_sweep_zero;  // blank the cell at the sweep address
    logic wr_cur_zero;    // blank the cursor cell
    logic wr_char;        // write the latched byte and advance
    logic put_space;      // write a space and advance, one tab step
    logic new_line;       // cursor to the start of the next row
    logic back_step;      // cursor one cell back
    logic scroll_end;     // row back to the last screen row
    logic finish;         // cursor mark and result register load
  } cmd_t;

  typedef struct packed {
    logic        scroll_pending;
    logic        sweep_last_move;
    logic        sweep_last_cell;
    logic        at_origin;
    logic        cell_nonzero;
    logic        tab_last;
    logic        out_free;
    item_class_t item_cls;
  } stat_t;

  function automatic item_class_t classify(input logic kind, input logic [CHAR_W-1:0] ch);
    item_class_t cls;
    if (kind == KIND_READ) begin
      cls = CLS_READ;
    end else begin
      case (ch)
        CHAR_NEWLINE:   cls = CLS_NEWLINE;
        CHAR_BACKSPACE: cls = CLS_BACKSPACE;
        CHAR_TAB:       cls = CLS_TAB;
        default:        cls = CLS_PLAIN;
      endcase
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ design/tmcw_ifs.sv @@
// Valid/ready channel interfaces for the console writer's item and result words.
// Depends on tmcw_pkg for the payload types.
`default_nettype none

interface tmcw_item_if;
  import tmcw_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tmcw_result_if;
  import tmcw_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/tmcw_datapath.sv @@
// Datapath of the console writer: screen memory, cursor, color register,
// sweep and tab counters and the result register. Depends on tmcw_pkg.
`default_nettype none

module tmcw_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  tmcw_pkg::cmd_t               cmd,
  output tmcw_pkg::stat_t              stat,
  input  tmcw_pkg::item_t              item_payload,
  input  logic                         cfg_write_en,
  input  logic [tmcw_pkg::COLOR_W-1:0] cfg_write_data,
  output logic                         result_valid,
  input  logic                         result_ready,
  output tmcw_pkg::result_t            result_payload
);
  import tmcw_pkg::*;

  logic [DATA_W-1:0]  screen [CELLS];
  logic [DATA_W-1:0]  cell_rdata;

  logic [COL_W-1:0]   column, column_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COLOR_W-1:0] char_color;
  logic [ADDR_W-1:0]  sweep;
  logic [TAB_W-1:0]   tab_count;

  logic               item_kind;
  logic [CHAR_W-1:0]  item_char;
  logic [IDX_W-1:0]   item_index;
  logic               item_in_range;
  item_class_t        item_cls;

  logic [ADDR_W-1:0]  cur_addr;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0]  wr_data;
  logic               offered_in_range;
  logic               cursor_on_screen;

  assign cur_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(column);
  assign offered_in_range = item_payload.cell_index < IDX_W'(CELLS);
  assign cursor_on_screen = row < ROW_W'(ROWS);

  // Cursor movement.
  always_comb begin
    column_next = column;
    row_next    = row;
    if (cmd.wr_char || cmd.put_space) begin
      if (column == COL_W'(COLUMNS - 1)) begin
        column_next = '0;
        row_next    = row + 1'b1;
      end else begin
        column_next = column + 1'b1;
      end
    end else if (cmd.new_line) begin
      column_next = '0;
      row_next    = row + 1'b1;
    end else if (cmd.back_step) begin
      if (column != '0) begin
        column_next = column - 1'b1;
      end else begin
        column_next = COL_W'(COLUMNS - 1);
        row_next    = row - 1'b1;
      end
    end else if (cmd.scroll_end) begin
      row_next = ROW_W'(ROWS - 1);
    end
  end

  // Write port selection.
  always_comb begin
    mem_we  = 1'b1;
    wr_addr = cur_addr;
    wr_data = '0;
    if (cmd.wr_sweep_copy) begin
      wr_addr = sweep;
      wr_data = cell_rdata;
    end else if (cmd.wr_sweep_zero) begin
      wr_addr = sweep;
    end else if (cmd.wr_cur_zero) begin
      wr_data = '0;
    end else if (cmd.wr_char) begin
      wr_data = {char_color, item_char};
    end else if (cmd.put_space) begin
      wr_data = {char_color, CHAR_SPACE};
    end else if (cmd.finish && item_kind == KIND_PUT && cursor_on_screen) begin
      wr_data = CURSOR_MARK;
    end else begin
      mem_we = 1'b0;
    end
  end

  // Read port selection.
  always_comb begin
    mem_re  = 1'b1;
    rd_addr = cur_addr;
    if (cmd.rd_item && item_in_range) begin
      rd_addr = ADDR_W'(item_index);
    end else if (cmd.rd_sweep) begin
      rd_addr = sweep + ADDR_W'(COLUMNS);
    end else if (cmd.rd_cursor) begin
      rd_addr = cur_addr;
    end else begin
      mem_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      cell_rdata <= screen[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row          <= '0;
      char_color   <= COLOR_RESET;
      sweep        <= '0;
      tab_count    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        char_color <= cfg_write_data;
      end
      if (cmd.sweep_clr) begin
        sweep <= '0;
      end else if (cmd.sweep_inc) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.accept) begin
        tab_count <= TAB_W'(TAB_SPACES - 1);
      end else if (cmd.put_space) begin
        tab_count <= tab_count - 1'b1;
      end
      column <= column_next;
      row    <= row_next;
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Latched word and result register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind     <= item_payload.kind;
      item_char     <= item_payload.char_code;
      item_index    <= item_payload.cell_index;
      item_in_range <= offered_in_range;
      item_cls      <= classify(item_payload.kind, item_payload.char_code);
    end
    if (cmd.finish) begin
      result_payload.cell_data     <= (item_kind == KIND_READ && item_in_range) ?
                                      cell_rdata : '0;
      result_payload.cursor_column <= column;
      result_payload.cursor_row    <= row;
    end
  end

  assign stat.scroll_pending  = !cursor_on_screen;
  assign stat.sweep_last_move = sweep == ADDR_W'(MOVE_CELLS - 1);
  assign stat.sweep_last_cell = sweep == ADDR_W'(CELLS - 1);
  assign stat.at_origin       = column == '0 && row == '0;
  assign stat.cell_nonzero    = cell_rdata != '0;
  assign stat.tab_last        = tab_count == '0;
  assign stat.out_free        = !result_valid || result_ready;
  assign stat.item_cls        = item_cls;

endmodule

`default_nettype wire

@@ design/tmcw_ctrl.sv @@
// Controller state machine of the console writer: sequences scrolls, byte
// handling, backspace walks and result loads. Depends on tmcw_pkg.
`default_nettype none

module tmcw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  tmcw_pkg::item_class_t item_cls,
  output logic                  item_ready,
  input  tmcw_pkg::stat_t       stat,
  output tmcw_pkg::cmd_t        cmd
);
  import tmcw_pkg::*;

  typedef enum logic [13:0] {
    ST_CLEAR     = 14'b00000000000001,
    ST_IDLE      = 14'b00000000000010,
    ST_SCROLL_RD = 14'b00000000000100,
    ST_SCROLL_WR = 14'b00000000001000,
    ST_BLANK     = 14'b00000000010000,
    ST_PUT       = 14'b00000000100000,
    ST_TAB       = 14'b00000001000000,
    ST_NEWLINE   = 14'b00000010000000,
    ST_BS_BLANK  = 14'b00000100000000,
    ST_BS_STEP   = 14'b00001000000000,
    ST_BS_READ   = 14'b00010000000000,
    ST_BS_CHECK  = 14'b00100000000000,
    ST_FINISH    = 14'b01000000000000,
    ST_READ      = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // First state of a word, given its class and whether a scroll is owed.
  function automatic state_t dispatch(input item_class_t cls, input logic pending);
    state_t st;
    if (cls == CLS_READ) begin
      st = ST_READ;
    end else if (pending) begin
      st = ST_SCROLL_RD;
    end else begin
      case (cls)
        CLS_NEWLINE:   st = ST_NEWLINE;
        CLS_BACKSPACE: st = ST_BS_BLANK;
        CLS_TAB:       st = ST_TAB;
        default:       st = ST_PUT;
      endcase
    end
    return st;
  endfunction

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.wr_sweep_zero = 1'b1;
        cmd.sweep_inc     = 1'b1;
        if (stat.sweep_last_cell) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept    = 1'b1;
          cmd.sweep_clr = 1'b1;
          state_next    = dispatch(item_cls, stat.scroll_pending);
        end
      end
      ST_READ: begin
        // The read comes in the cycle after the accept, so it sees the cursor mark
        // that the previous word wrote while this one was being accepted.
        cmd.rd_item = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_SCROLL_RD: begin
        cmd.rd_sweep = 1'b1;
        state_next   = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        cmd.wr_sweep_copy = 1'b1;
        cmd.sweep_inc     = 1'b1;
        state_next        = stat.sweep_last_move ? ST_BLANK : ST_SCROLL_RD;
      end
      ST_BLANK: begin
        cmd.wr_sweep_zero = 1'b1;
        cmd.sweep_inc     = 1'b1;
        if (stat.sweep_last_cell) begin
          cmd.scroll_end = 1'b1;
          state_next     = dispatch(stat.item_cls, 1'b0);
        end
      end
      ST_PUT: begin
        cmd.wr_char = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_TAB: begin
        if (stat.scroll_pending) begin
          cmd.sweep_clr = 1'b1;
          state_next    = ST_SCROLL_RD;
        end else begin
          cmd.put_space = 1'b1;
          state_next    = stat.tab_last ? ST_FINISH : ST_TAB;
        end
      end
      ST_NEWLINE: begin
        cmd.wr_cur_zero = 1'b1;
        cmd.new_line    = 1'b1;
        state_next      = ST_FINISH;
      end
      ST_BS_BLANK: begin
        cmd.wr_cur_zero = 1'b1;
        state_next      = ST_BS_STEP;
      end
      ST_BS_STEP: begin
        if (stat.at_origin) begin
          state_next = ST_FINISH;
        end else begin
          cmd.back_step = 1'b1;
          state_next    = ST_BS_READ;
        end
      end
      ST_BS_READ: begin
        cmd.rd_cursor = 1'b1;
        state_next    = ST_BS_CHECK;
      end
      ST_BS_CHECK: begin
        state_next = stat.cell_nonzero ? ST_FINISH : ST_BS_STEP;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          item_ready = 1'b1;
          if (item_valid) begin
            cmd.accept    = 1'b1;
            cmd.sweep_clr = 1'b1;
            state_next    = dispatch(item_cls, stat.scroll_pending);
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ design/text_mode_console_writer_core.sv @@
// Top level of the text-mode console writer: joins the controller and the datapath
// to the item, result and configuration ports. Depends on tmcw_pkg, tmcw_ifs,
// tmcw_ctrl and tmcw_datapath.
//
//   Channel  Direction  Handshake            Word
//   item     in         valid/ready          kind, char_code, cell_index
//   result   out        valid/ready          cell_data, cursor_column, cursor_row
//   cfg      in         cfg_write_en only    char_color (8 bits)
//
// An ordinary byte, a newline or a cell read is handled and then finished; a tab writes
// TAB_SPACES spaces. A backspace blanks the cursor cell, then walks back one cell at a
// time, reading each, until it finds a written cell or reaches the origin. A pending
// scroll first moves the rows up and then blanks the last row, also when it falls between
// the spaces of a tab: each moved cell needs a read and then a write through the
// single read and write ports of the screen memory.
// After reset the block clears the screen one cell a cycle and holds item ready low
// meanwhile; the color register can be written all along.
// When the result register is still full, the finishing step waits and item ready stays low.
`default_nettype none

module text_mode_console_writer_core (
  input  logic                         clk,
  input  logic                         rst,
  tmcw_item_if.sink                    item,
  tmcw_result_if.source                result,
  input  logic                         cfg_write_en,
  input  logic [tmcw_pkg::COLOR_W-1:0] cfg_write_data
);
  import tmcw_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  item_class_t item_cls;

  // The class of the offered word lets the controller pick the first step in the
  // same cycle that it accepts the word, so back-to-back words need no idle state between.
  assign item_cls = classify(item.payload.kind, item.payload.char_code);

  tmcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_cls   (item_cls),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath owns the screen memory and the cursor; the result register in it
  // decouples the result side, so a new word is taken while a result waits.
  tmcw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .item_payload   (item.payload),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
  );

  // A shown cursor always lies on the screen or on the row just below it.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.payload.cursor_column < COL_W'(COLUMNS) &&
                      result.payload.cursor_row <= ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result register overwritten");

  // At most one source drives the memory write port in a cycle.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_sweep_copy, cmd.wr_sweep_zero, cmd.wr_cur_zero,
              cmd.wr_char, cmd.put_space, cmd.finish}))
    else $error("conflicting screen writes");

endmodule

`default_nettype wire
